// ----- sv/pdsc_pkg.sv -----
// pdsc_pkg: types shared by the frame deframer controller, datapath and top level
// no dependencies

package pdsc_pkg;

  typedef enum logic [2:0] {
    ST_ID,
    ST_PAYLOAD,
    ST_CHECK,
    ST_RD,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic load_id;
    logic store;
    logic check;
    logic rd;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic sum_match;
    logic at_last;
  } sts_t;

endpackage

// ----- sv/packet_deframer_sum_check.sv -----
// packet_deframer_sum_check: top level of the fixed-length frame deframer
// depends on pdsc_pkg, pdsc_ctrl and pdsc_dpath

// Receives one byte per transfer: an id byte, PAYLOAD_BYTES payload bytes and a checksum
// byte equal to the 8-bit wrapping sum of id and payload. While a frame is received a byte
// is taken every cycle. After a matching checksum the block stalls its input and sends
// PAYLOAD_BYTES + 1 results (payload bytes in order, then the checksum byte marked last).
// Each payload result is read from the payload ram through its registered read port and
// then presented. A frame with a bad checksum is dropped without output and the next byte
// is taken as an id. No clearing pass is needed after reset.

module packet_deframer_sum_check
  import pdsc_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_id,
  output logic [4:0] out_byte_index,
  output logic [7:0] out_data_byte,
  output logic       out_last_byte
);

  cmd_t cmd;
  sts_t sts;

  pdsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  pdsc_dpath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rx_byte    (in_rx_byte),
    .sts        (sts),
    .frame_id   (out_frame_id),
    .byte_index (out_byte_index),
    .data_byte  (out_data_byte),
    .last_byte  (out_last_byte)
  );

`ifndef SYNTH
  a_no_rx_during_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during result burst");

  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_byte) |=> !out_valid)
    else $error("result after last byte of frame");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_byte) |-> ##2
      (out_valid && out_byte_index == 5'($past(out_byte_index, 2) + 5'd1)))
    else $error("byte index did not advance by one");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |-> (out_byte_index == 5'(PAYLOAD_BYTES)))
    else $error("last byte at wrong index");
`endif

endmodule

// ----- sv/pdsc_ram.sv -----
// pdsc_ram: generic single-port ram with registered read
// no dependencies

module pdsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/pdsc_ctrl.sv -----
// pdsc_ctrl: frame sequencing state machine
// depends on pdsc_pkg

module pdsc_ctrl
  import pdsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_stall,
  output logic out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ID;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_ID: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_id = 1'b1;
          state_nxt   = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (sts.fill_last) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.check = 1'b1;
          state_nxt = sts.sum_match ? ST_RD : ST_ID;
        end
      end
      ST_RD: begin
        // checksum byte comes from its own register, no read
        cmd.rd    = !sts.at_last;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.at_last) begin
            state_nxt = ST_ID;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_ID;
      end
    endcase
  end

endmodule

// ----- sv/pdsc_dpath.sv -----
// pdsc_dpath: id, running sum, fill counter, checksum register and payload ram
// depends on pdsc_pkg and pdsc_ram

module pdsc_dpath
  import pdsc_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic [7:0] rx_byte,
  output sts_t       sts,
  output logic [7:0] frame_id,
  output logic [4:0] byte_index,
  output logic [7:0] data_byte,
  output logic       last_byte
);

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CW = $clog2(PAYLOAD_BYTES + 1);

  logic [7:0]    held_id_r, held_id_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    chk_r, chk_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [7:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_id_r <= '0;
      sum_r     <= '0;
      fill_r    <= '0;
    end else begin
      held_id_r <= held_id_nxt;
      sum_r     <= sum_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
  end

  always_comb begin
    held_id_nxt = held_id_r;
    sum_nxt     = sum_r;
    chk_nxt     = chk_r;
    fill_nxt    = fill_r;
    if (cmd.load_id) begin
      held_id_nxt = rx_byte;
      sum_nxt     = rx_byte;
      fill_nxt    = '0;
    end
    if (cmd.store) begin
      sum_nxt  = sum_r + rx_byte;
      fill_nxt = fill_r + CW'(1);
    end
    if (cmd.check) begin
      chk_nxt  = rx_byte;
      fill_nxt = '0;
    end
    if (cmd.step) begin
      fill_nxt = fill_r + CW'(1);
    end
  end

  pdsc_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.store),
    .re    (cmd.rd),
    .addr  (fill_r[AW-1:0]),
    .wdata (rx_byte),
    .rdata (ram_rdata)
  );

  assign sts.fill_last = (fill_r == CW'(PAYLOAD_BYTES - 1));
  assign sts.sum_match = (rx_byte == sum_r);
  assign sts.at_last   = (fill_r == CW'(PAYLOAD_BYTES));

  assign frame_id   = held_id_r;
  assign byte_index = 5'(fill_r);
  assign data_byte  = sts.at_last ? chk_r : ram_rdata;
  assign last_byte  = sts.at_last;

endmodule
